// ----- rtl/core/rbi_pkg.sv -----
// Shared types, widths and constants for the ray versus box intersection block.
package rbi_pkg;

   // Fixed-point format of every coordinate and of the distance.
   localparam int FRAC_BITS = 16;

   localparam int AXES = 3;
   // Width of one coordinate field.
   localparam int CW = 32;
   // Magnitude of a coordinate difference, which can reach 2^32 - 1.
   localparam int MW = CW + 1;
   // Dividend and quotient width of the distance division.
   localparam int NW = MW + FRAC_BITS;
   // Partial remainder width of the restoring divider.
   localparam int RW = MW + 1;
   // Signed candidate distance width.
   localparam int TW = NW + 1;
   // Split point of the distance for the two partial products.
   localparam int SPLIT = NW / 2;
   // Full product width of distance times direction magnitude.
   localparam int PW = NW + MW;
   // Products above 2^LIMIT_SHIFT put the point far off any box.
   localparam int LIMIT_SHIFT = FRAC_BITS + CW + 2;
   // Offset width kept after the product is scaled back.
   localparam int OW = CW + 4;
   // Width of the shifted coordinate that is compared against the box.
   localparam int CMPW = OW + 2;

   // Depth of the queue between front and back; a power of two.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   // Axis codes.
   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } rbi_axis_type;

   // One classified item as the front hands it to the back.
   typedef struct packed {
      logic                         start_in;
      logic [AXES-1:0]              used;
      logic [AXES-1:0]              num_neg;
      logic [AXES-1:0]              d_neg;
      logic [AXES-1:0]              d_zero;
      logic [AXES-1:0][CW-1:0]      s;
      logic [AXES-1:0][CW-1:0]      lo;
      logic [AXES-1:0][CW-1:0]      hi;
      logic [AXES-1:0][MW-1:0]      num_mag;
      logic [AXES-1:0][MW-1:0]      d_mag;
   } rbi_item_type;

endpackage

// ----- rtl/core/rbi_front.sv -----
// Front stage: takes a ray and a box, finds the entry planes and registers the classified item.
module rbi_front
   import rbi_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [AXES-1:0][CW-1:0]  start,
   input  logic [AXES-1:0][CW-1:0]  toward,
   input  logic [AXES-1:0][CW-1:0]  box_lo,
   input  logic [AXES-1:0][CW-1:0]  box_hi,
   output logic                     item_valid,
   input  logic                     item_ready,
   output rbi_item_type             item
);

   logic          valid_ff, valid_in;
   rbi_item_type  item_ff, item_in;
   logic          advance;

   logic [MW-1:0] d_diff   [AXES];
   logic [MW-1:0] num_diff [AXES];
   logic [CW-1:0] face     [AXES];
   logic          above    [AXES];
   logic          below    [AXES];

   // The stage moves when it is empty or its item goes into the queue.
   assign advance   = !valid_ff || item_ready;
   assign req_ready = advance;
   assign valid_in  = advance ? req_valid : valid_ff;

   // Direction, near face and distance to it on each axis.
   always_comb begin
      item_in = '0;
      for (int a = 0; a < AXES; a++) begin
         d_diff[a] = {toward[a][CW-1], toward[a]} - {start[a][CW-1], start[a]};
         above[a]  = $signed(start[a]) > $signed(box_hi[a]);
         below[a]  = $signed(start[a]) < $signed(box_lo[a]);
         face[a]   = above[a] ? box_hi[a] : box_lo[a];
         num_diff[a] = {face[a][CW-1], face[a]} - {start[a][CW-1], start[a]};

         item_in.used[a]    = above[a] || below[a];
         item_in.d_neg[a]   = d_diff[a][MW-1];
         item_in.d_zero[a]  = (d_diff[a] == '0);
         item_in.d_mag[a]   = d_diff[a][MW-1] ? (~d_diff[a] + MW'(1)) : d_diff[a];
         item_in.num_neg[a] = num_diff[a][MW-1];
         item_in.num_mag[a] = num_diff[a][MW-1] ? (~num_diff[a] + MW'(1)) : num_diff[a];
         item_in.s[a]       = start[a];
         item_in.lo[a]      = box_lo[a];
         item_in.hi[a]      = box_hi[a];
      end
      item_in.start_in = ~|item_in.used;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_valid) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ----- rtl/core/rbi_queue.sv -----
// Short queue that parts the front from the back.
module rbi_queue
   import rbi_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  rbi_item_type  in_item,
   output logic          out_valid,
   input  logic          out_ready,
   output rbi_item_type  out_item
);

   rbi_item_type      mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              push, pop;

   assign in_ready  = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// ----- rtl/core/rbi_back.sv -----
// Back pipeline: divides out the plane distances, picks the entry plane and checks the hit point.
module rbi_back
   import rbi_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   output logic          q_ready,
   input  rbi_item_type  q_item,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_hit,
   output logic          rsp_start_inside,
   output logic [CW-1:0] rsp_hit_distance
);

   localparam logic [TW-1:0] NEG_ONE = ~(TW'(1) << FRAC_BITS) + TW'(1);
   localparam logic [PW-1:0] LIMIT   = PW'(1) << LIMIT_SHIFT;

   // The whole back pipeline moves together unless the result waits.
   logic advance;
   logic out_valid_ff;
   assign advance = !out_valid_ff || rsp_ready;
   assign q_ready = advance;

   // Restoring divider: one quotient bit per stage on each axis.
   logic                          dv_valid_ff [NW];
   rbi_item_type                  dv_item_ff  [NW];
   logic [AXES-1:0][RW-1:0]       rem_ff      [NW];
   logic [AXES-1:0][NW-1:0]       dq_ff       [NW];

   for (genvar k = 0; k < NW; k++) begin : g_div
      logic                    v_src;
      rbi_item_type            it_src;
      logic [AXES-1:0][RW-1:0] rem_src, rem_in;
      logic [AXES-1:0][NW-1:0] dq_src, dq_in;
      logic [RW-1:0]           rem_sh [AXES];
      logic [RW:0]             trial  [AXES];

      if (k == 0) begin : g_first
         assign v_src  = q_valid;
         assign it_src = q_item;
         always_comb begin
            for (int a = 0; a < AXES; a++) begin
               rem_src[a] = '0;
               dq_src[a]  = {q_item.num_mag[a], {FRAC_BITS{1'b0}}};
            end
         end
      end else begin : g_next
         assign v_src   = dv_valid_ff[k-1];
         assign it_src  = dv_item_ff[k-1];
         assign rem_src = rem_ff[k-1];
         assign dq_src  = dq_ff[k-1];
      end

      // Shift in the next dividend bit and subtract the divisor when it fits.
      always_comb begin
         for (int a = 0; a < AXES; a++) begin
            rem_sh[a] = {rem_src[a][RW-2:0], dq_src[a][NW-1]};
            trial[a]  = {1'b0, rem_sh[a]} - {{(RW+1-MW){1'b0}}, it_src.d_mag[a]};
            dq_in[a]  = dq_src[a] << 1;
            if (!trial[a][RW]) begin
               rem_in[a]   = trial[a][RW-1:0];
               dq_in[a][0] = 1'b1;
            end else begin
               rem_in[a] = rem_sh[a];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k] <= 1'b0;
         end else if (advance) begin
            dv_valid_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            dv_item_ff[k] <= it_src;
            rem_ff[k]     <= rem_in;
            dq_ff[k]      <= dq_in;
         end
      end
   end

   // Signed candidate distance per axis; idle axes get minus one.
   logic                    t_valid_ff;
   rbi_item_type            t_item_ff;
   logic [AXES-1:0][TW-1:0] t_ff, t_in;

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         if (dv_item_ff[NW-1].used[a] && !dv_item_ff[NW-1].d_zero[a]) begin
            if (dv_item_ff[NW-1].num_neg[a] ^ dv_item_ff[NW-1].d_neg[a]) begin
               t_in[a] = ~{1'b0, dq_ff[NW-1][a]} + TW'(1);
            end else begin
               t_in[a] = {1'b0, dq_ff[NW-1][a]};
            end
         end else begin
            t_in[a] = NEG_ONE;
         end
      end
   end

   // Entry plane: the largest candidate, ties resolved toward the later axis.
   logic          s_valid_ff;
   rbi_item_type  s_item_ff;
   rbi_axis_type  mp_ff, mp_in;
   logic [NW-1:0] tm_ff, tm_in;
   logic          miss_ff, miss_in;
   logic [TW-1:0] t_sel;

   always_comb begin
      if ($signed(t_ff[AXIS_X]) > $signed(t_ff[AXIS_Y])) begin
         mp_in = ($signed(t_ff[AXIS_X]) > $signed(t_ff[AXIS_Z])) ? AXIS_X : AXIS_Z;
      end else begin
         mp_in = ($signed(t_ff[AXIS_Y]) > $signed(t_ff[AXIS_Z])) ? AXIS_Y : AXIS_Z;
      end
      unique case (mp_in)
         AXIS_X:  t_sel = t_ff[AXIS_X];
         AXIS_Y:  t_sel = t_ff[AXIS_Y];
         AXIS_Z:  t_sel = t_ff[AXIS_Z];
         default: t_sel = t_ff[AXIS_Z];
      endcase
      miss_in = t_sel[TW-1];
      tm_in   = t_sel[NW-1:0];
   end

   // Partial products of the distance and each direction magnitude.
   logic                             m_valid_ff;
   rbi_item_type                     m_item_ff;
   rbi_axis_type                     m_mp_ff;
   logic [NW-1:0]                    m_tm_ff;
   logic                             m_miss_ff;
   logic [AXES-1:0][SPLIT+MW-1:0]    pl_ff, pl_in;
   logic [AXES-1:0][NW-SPLIT+MW-1:0] ph_ff, ph_in;

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         pl_in[a] = tm_ff[SPLIT-1:0] * s_item_ff.d_mag[a];
         ph_in[a] = tm_ff[NW-1:SPLIT] * s_item_ff.d_mag[a];
      end
   end

   // Full product, the far-off check and the scaled offset.
   logic                    p_valid_ff;
   rbi_item_type            p_item_ff;
   rbi_axis_type            p_mp_ff;
   logic [NW-1:0]           p_tm_ff;
   logic                    p_miss_ff;
   logic [AXES-1:0]         far_ff, far_in;
   logic [AXES-1:0][OW-1:0] off_ff, off_in;
   logic [PW-1:0]           prod [AXES];

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         prod[a]   = PW'(pl_ff[a]) + (PW'(ph_ff[a]) << SPLIT);
         far_in[a] = prod[a] > LIMIT;
         off_in[a] = prod[a][FRAC_BITS +: OW];
      end
   end

   // Hit point on the other axes must lie on the box.
   logic            c_valid_ff;
   logic            c_inside_ff;
   logic [NW-1:0]   c_tm_ff;
   logic            c_miss_ff;
   logic [AXES-1:0] ok_ff, ok_in;
   logic [CMPW-1:0] comp   [AXES];
   logic [CMPW-1:0] s_ext  [AXES];
   logic [CMPW-1:0] lo_ext [AXES];
   logic [CMPW-1:0] hi_ext [AXES];

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         s_ext[a]  = {{(CMPW-CW){p_item_ff.s[a][CW-1]}}, p_item_ff.s[a]};
         lo_ext[a] = {{(CMPW-CW){p_item_ff.lo[a][CW-1]}}, p_item_ff.lo[a]};
         hi_ext[a] = {{(CMPW-CW){p_item_ff.hi[a][CW-1]}}, p_item_ff.hi[a]};
         if (p_item_ff.d_neg[a]) begin
            comp[a] = s_ext[a] - {{(CMPW-OW){1'b0}}, off_ff[a]};
         end else begin
            comp[a] = s_ext[a] + {{(CMPW-OW){1'b0}}, off_ff[a]};
         end
         ok_in[a] = (p_mp_ff == rbi_axis_type'(a)) ||
                    (!far_ff[a] && ($signed(comp[a]) >= $signed(lo_ext[a])) &&
                     ($signed(comp[a]) <= $signed(hi_ext[a])));
      end
   end

   // Result register.
   logic          hit_ff, hit_in;
   logic          inside_ff;
   logic [CW-1:0] dist_ff, dist_in;

   always_comb begin
      hit_in = c_inside_ff || (!c_miss_ff && (&ok_ff));
      if (hit_in && !c_inside_ff) begin
         dist_in = (|c_tm_ff[NW-1:CW]) ? '1 : c_tm_ff[CW-1:0];
      end else begin
         dist_in = '0;
      end
   end

   // Valid bits of the stages after the divider.
   always_ff @(posedge clock) begin
      if (reset) begin
         t_valid_ff   <= 1'b0;
         s_valid_ff   <= 1'b0;
         m_valid_ff   <= 1'b0;
         p_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         t_valid_ff   <= dv_valid_ff[NW-1];
         s_valid_ff   <= t_valid_ff;
         m_valid_ff   <= s_valid_ff;
         p_valid_ff   <= m_valid_ff;
         c_valid_ff   <= p_valid_ff;
         out_valid_ff <= c_valid_ff;
      end
   end

   // Payload of the stages after the divider.
   always_ff @(posedge clock) begin
      if (advance) begin
         t_item_ff   <= dv_item_ff[NW-1];
         t_ff        <= t_in;
         s_item_ff   <= t_item_ff;
         mp_ff       <= mp_in;
         tm_ff       <= tm_in;
         miss_ff     <= miss_in;
         m_item_ff   <= s_item_ff;
         m_mp_ff     <= mp_ff;
         m_tm_ff     <= tm_ff;
         m_miss_ff   <= miss_ff;
         pl_ff       <= pl_in;
         ph_ff       <= ph_in;
         p_item_ff   <= m_item_ff;
         p_mp_ff     <= m_mp_ff;
         p_tm_ff     <= m_tm_ff;
         p_miss_ff   <= m_miss_ff;
         far_ff      <= far_in;
         off_ff      <= off_in;
         c_inside_ff <= p_item_ff.start_in;
         c_tm_ff     <= p_tm_ff;
         c_miss_ff   <= p_miss_ff;
         ok_ff       <= ok_in;
         hit_ff      <= hit_in;
         inside_ff   <= c_inside_ff;
         dist_ff     <= dist_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_hit          = hit_ff;
   assign rsp_start_inside = inside_ff;
   assign rsp_hit_distance = dist_ff;

endmodule

// ----- rtl/core/ray_box_intersection.sv -----
// Top level of the ray versus axis-aligned box intersection block.
// Each transfer on the req_ channel carries a ray start, a second point on the
// ray and a box, all in signed Q16.16; each yields exactly one transfer on the
// rsp_ channel, in order, with the hit flag, the start-inside flag and the
// entry distance in unsigned Q16.16 (saturated, zero on a miss or when the
// start is inside). The block accepts one item per cycle while rsp_ready is
// high. Each item passes the front register, the queue, the pipelined restoring
// divider that resolves one quotient bit per stage and the candidate, entry,
// product, check and result registers to rsp_valid; a two-entry queue lets the
// classifying front keep accepting while the back waits on rsp_ready.
module ray_box_intersection
   import rbi_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [CW-1:0] req_start_x,
   input  logic [CW-1:0] req_start_y,
   input  logic [CW-1:0] req_start_z,
   input  logic [CW-1:0] req_toward_x,
   input  logic [CW-1:0] req_toward_y,
   input  logic [CW-1:0] req_toward_z,
   input  logic [CW-1:0] req_box_lo_x,
   input  logic [CW-1:0] req_box_lo_y,
   input  logic [CW-1:0] req_box_lo_z,
   input  logic [CW-1:0] req_box_hi_x,
   input  logic [CW-1:0] req_box_hi_y,
   input  logic [CW-1:0] req_box_hi_z,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_hit,
   output logic          rsp_start_inside,
   output logic [CW-1:0] rsp_hit_distance
);

   logic [AXES-1:0][CW-1:0] start, toward, box_lo, box_hi;
   logic                    f_valid, f_ready;
   rbi_item_type            f_item;
   logic                    q_valid, q_ready;
   rbi_item_type            q_item;

   // Gather the per-axis fields.
   assign start  = {req_start_z, req_start_y, req_start_x};
   assign toward = {req_toward_z, req_toward_y, req_toward_x};
   assign box_lo = {req_box_lo_z, req_box_lo_y, req_box_lo_x};
   assign box_hi = {req_box_hi_z, req_box_hi_y, req_box_hi_x};

   rbi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .start      (start),
      .toward     (toward),
      .box_lo     (box_lo),
      .box_hi     (box_hi),
      .item_valid (f_valid),
      .item_ready (f_ready),
      .item       (f_item)
   );

   rbi_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_item   (f_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   rbi_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_ready          (q_ready),
      .q_item           (q_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_start_inside (rsp_start_inside),
      .rsp_hit_distance (rsp_hit_distance)
   );

endmodule
